@@ src/cltok_pkg.sv @@
// Package of the command line tokenizer: constants, phase codes and shared types.
`default_nettype none
package cltok_pkg;

    // Length and count limits of one line.
    localparam logic [5:0] NAME_MAX = 6'd32;
    localparam logic [6:0] ARG_MAX  = 7'd64;
    localparam logic [1:0] ARGS_MAX = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // Parse phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_EXPECT = 3'd2;
    localparam logic [2:0] PH_BARE   = 3'd3;
    localparam logic [2:0] PH_QUOTED = 3'd4;
    localparam logic [2:0] PH_CLOSED = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    // Event kinds.
    localparam logic [1:0] EV_CHAR  = 2'd0;
    localparam logic [1:0] EV_READY = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    // Syntax error codes.
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_BAD_START  = 4'd1;
    localparam logic [3:0] ERR_NAME_LONG  = 4'd2;
    localparam logic [3:0] ERR_NAME_CHAR  = 4'd3;
    localparam logic [3:0] ERR_MISSING    = 4'd4;
    localparam logic [3:0] ERR_EXTRA_SP   = 4'd5;
    localparam logic [3:0] ERR_TOO_MANY   = 4'd6;
    localparam logic [3:0] ERR_ARG_LONG   = 4'd7;
    localparam logic [3:0] ERR_JUNK_QUOTE = 4'd8;

    typedef struct packed {
        logic [2:0] phase;
        logic [5:0] name_idx;
        logic [6:0] arg_idx;
        logic [1:0] args;
        logic [6:0] len1;
        logic [6:0] len2;
        logic       esc;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_IDLE, name_idx: 6'd0, arg_idx: 7'd0, args: 2'd0,
        len1: 7'd0, len2: 7'd0, esc: 1'b0
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [3:0] err;
        logic [1:0] slot;
        logic [5:0] pos;
        logic [7:0] ch;
        logic [1:0] argc;
        logic [5:0] name_len;
        logic [6:0] len1;
        logic [6:0] len2;
    } t_result;

endpackage
`default_nettype wire

@@ src/cltok_parse.sv @@
// Per-byte step of the tokenizer: next line state and the word it produces.
`default_nettype none
module cltok_parse (
    input  wire logic [7:0]       i_byte,
    input  wire cltok_pkg::t_state  i_state,
    output cltok_pkg::t_state       o_state,
    output cltok_pkg::t_result      o_result
);

    logic       is_eol;
    logic       is_blank;
    logic       is_alpha;
    logic       is_alnum;
    logic       do_store;
    logic       do_end_arg;
    logic       do_ready;
    logic       do_fail;
    logic [3:0] fail_code;
    logic [6:0] ready_len1;
    logic [6:0] ready_len2;

    assign is_eol   = (i_byte == cltok_pkg::CH_CR) || (i_byte == cltok_pkg::CH_LF);
    assign is_blank = (i_byte == cltok_pkg::CH_SPACE) || (i_byte == cltok_pkg::CH_TAB);
    assign is_alpha = ((i_byte >= 8'h41) && (i_byte <= 8'h5A))
                   || ((i_byte >= 8'h61) && (i_byte <= 8'h7A));
    assign is_alnum = is_alpha || ((i_byte >= 8'h30) && (i_byte <= 8'h39));

    always_comb begin
        o_state    = i_state;
        o_result   = '0;
        do_store   = 1'b0;
        do_end_arg = 1'b0;
        do_ready   = 1'b0;
        do_fail    = 1'b0;
        fail_code  = cltok_pkg::ERR_NONE;
        ready_len1 = 7'd0;
        ready_len2 = 7'd0;

        unique case (i_state.phase)
            cltok_pkg::PH_IDLE: begin
                if (is_alpha) begin
                    o_state.name_idx = 6'd1;
                    o_state.phase    = cltok_pkg::PH_NAME;
                    o_result.valid   = 1'b1;
                    o_result.kind    = cltok_pkg::EV_CHAR;
                    o_result.ch      = i_byte;
                    o_result.argc    = i_state.args;
                end else if (!is_eol) begin
                    do_fail   = 1'b1;
                    fail_code = cltok_pkg::ERR_BAD_START;
                end
            end
            cltok_pkg::PH_NAME: begin
                if (is_eol) begin
                    do_ready = 1'b1;
                end else if (is_blank) begin
                    o_state.phase = cltok_pkg::PH_EXPECT;
                end else if (is_alnum || (i_byte == cltok_pkg::CH_DASH)
                             || (i_byte == cltok_pkg::CH_UNDER)) begin
                    if (i_state.name_idx >= cltok_pkg::NAME_MAX) begin
                        do_fail   = 1'b1;
                        fail_code = cltok_pkg::ERR_NAME_LONG;
                    end else begin
                        o_state.name_idx = i_state.name_idx + 6'd1;
                        o_result.valid   = 1'b1;
                        o_result.kind    = cltok_pkg::EV_CHAR;
                        o_result.pos     = i_state.name_idx;
                        o_result.ch      = i_byte;
                        o_result.argc    = i_state.args;
                    end
                end else begin
                    do_fail   = 1'b1;
                    fail_code = cltok_pkg::ERR_NAME_CHAR;
                end
            end
            cltok_pkg::PH_EXPECT: begin
                o_state.arg_idx = 7'd0;
                if (is_eol) begin
                    // A trailing blank ends the line straight away, with no discard.
                    o_result.valid = 1'b1;
                    o_result.kind  = cltok_pkg::EV_ERROR;
                    o_result.err   = cltok_pkg::ERR_MISSING;
                    o_result.argc  = i_state.args;
                    o_state        = cltok_pkg::STATE_RESET;
                end else if (is_blank) begin
                    do_fail   = 1'b1;
                    fail_code = cltok_pkg::ERR_EXTRA_SP;
                end else if (i_state.args >= cltok_pkg::ARGS_MAX) begin
                    do_fail   = 1'b1;
                    fail_code = cltok_pkg::ERR_TOO_MANY;
                end else begin
                    o_state.args = i_state.args + 2'd1;
                    if (i_byte == cltok_pkg::CH_QUOTE) begin
                        o_state.esc   = 1'b0;
                        o_state.phase = cltok_pkg::PH_QUOTED;
                    end else begin
                        o_state.phase = cltok_pkg::PH_BARE;
                        do_store      = 1'b1;
                    end
                end
            end
            cltok_pkg::PH_BARE: begin
                if (is_eol) begin
                    do_end_arg = 1'b1;
                    do_ready   = 1'b1;
                end else if (is_blank) begin
                    do_end_arg    = 1'b1;
                    o_state.phase = cltok_pkg::PH_EXPECT;
                end else begin
                    do_store = 1'b1;
                end
            end
            cltok_pkg::PH_QUOTED: begin
                if ((i_byte == cltok_pkg::CH_QUOTE) || (i_byte == cltok_pkg::CH_BACKSLASH)) begin
                    if (i_state.esc) begin
                        o_state.esc = 1'b0;
                        do_store    = 1'b1;
                    end else if (i_byte == cltok_pkg::CH_QUOTE) begin
                        o_state.phase = cltok_pkg::PH_CLOSED;
                    end else begin
                        o_state.esc = 1'b1;
                    end
                end else begin
                    o_state.esc = 1'b0;
                    do_store    = 1'b1;
                end
            end
            cltok_pkg::PH_CLOSED: begin
                if (is_eol) begin
                    do_end_arg = 1'b1;
                    do_ready   = 1'b1;
                end else if (is_blank) begin
                    do_end_arg    = 1'b1;
                    o_state.phase = cltok_pkg::PH_EXPECT;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = cltok_pkg::ERR_JUNK_QUOTE;
                end
            end
            default: begin
                // Error phase: discard everything up to the line end.
                if (is_eol) begin
                    o_state = cltok_pkg::STATE_RESET;
                end
            end
        endcase

        // Close the current argument; a third argument keeps no length.
        if (do_end_arg) begin
            if (i_state.args == 2'd1) begin
                o_state.len1 = i_state.arg_idx;
            end else if (i_state.args == 2'd2) begin
                o_state.len2 = i_state.arg_idx;
            end
        end

        if (do_store) begin
            if (o_state.arg_idx >= cltok_pkg::ARG_MAX) begin
                do_fail   = 1'b1;
                fail_code = cltok_pkg::ERR_ARG_LONG;
            end else begin
                o_result.valid  = 1'b1;
                o_result.kind   = cltok_pkg::EV_CHAR;
                o_result.slot   = o_state.args;
                o_result.pos    = o_state.arg_idx[5:0];
                o_result.ch     = i_byte;
                o_result.argc   = o_state.args;
                o_state.arg_idx = o_state.arg_idx + 7'd1;
            end
        end

        if (do_fail) begin
            o_state.phase  = cltok_pkg::PH_ERROR;
            o_result.valid = 1'b1;
            o_result.kind  = cltok_pkg::EV_ERROR;
            o_result.err   = fail_code;
            o_result.argc  = o_state.args;
        end

        if (do_ready) begin
            ready_len1        = o_state.len1;
            ready_len2        = o_state.len2;
            o_result.valid    = 1'b1;
            o_result.kind     = cltok_pkg::EV_READY;
            o_result.argc     = i_state.args;
            o_result.name_len = i_state.name_idx;
            o_result.len1     = ready_len1;
            o_result.len2     = ready_len2;
            o_state           = cltok_pkg::STATE_RESET;
        end
    end

endmodule
`default_nettype wire

@@ src/command_line_tokenizer.sv @@
// Top level of the command line tokenizer: stream ports, line state and output register.
// A result word reaches the master side in the cycle after its byte is accepted.
// One byte per cycle unless output stalls; the line state updates in the accept cycle.
// The output register lets a new byte in while the previous result word is being taken.
// Reset is synchronous and active low: it clears the line state and empties the output.
`default_nettype none
module command_line_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] error_kind, [5:4] token_slot, [11:6] char_position, [19:12] char_byte,
    // [21:20] argument_count, [27:22] name_length, [34:28] first_arg_length,
    // [41:35] second_arg_length, [47:42] zero
    output logic [47:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser    // [1:0] event_kind
);

    cltok_pkg::t_state  r_state;
    cltok_pkg::t_state  n_state;
    cltok_pkg::t_result step_result;
    cltok_pkg::t_result r_out;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               accept;

    cltok_parse u_parse (
        .i_byte   (s_axis_tdata),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_result)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (accept) begin
            n_out_valid = step_result.valid;
        end else begin
            n_out_valid = r_out_valid && !m_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cltok_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_result.valid) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {6'd0, r_out.len2, r_out.len1, r_out.name_len, r_out.argc,
                            r_out.ch, r_out.pos, r_out.slot, r_out.err};

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench of the command line tokenizer: line generator, predictor and checker.

// One result word of the tokenizer, unpacked into its fields.
typedef struct packed {
    logic [1:0] kind;
    logic [3:0] err;
    logic [1:0] slot;
    logic [5:0] pos;
    logic [7:0] ch;
    logic [1:0] argc;
    logic [5:0] name_len;
    logic [6:0] len1;
    logic [6:0] len2;
} t_token_event;

function automatic bit is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
endfunction

function automatic bit is_name_byte(logic [7:0] b);
    return is_letter(b) || (b >= 8'h30 && b <= 8'h39)
        || b == cltok_pkg::CH_DASH || b == cltok_pkg::CH_UNDER;
endfunction

function automatic bit is_blank(logic [7:0] b);
    return b == cltok_pkg::CH_SPACE || b == cltok_pkg::CH_TAB;
endfunction

function automatic bit is_eol(logic [7:0] b);
    return b == cltok_pkg::CH_CR || b == cltok_pkg::CH_LF;
endfunction

class line_scoreboard;
    logic [2:0]   line_phase;
    logic [5:0]   name_len;
    logic [6:0]   arg_len;
    logic [1:0]   args_begun;
    logic [6:0]   first_len;
    logic [6:0]   second_len;
    logic         escaped;
    t_token_event expected_events[$];
    int           errors;

    function new();
        errors = 0;
        clear_line();
    endfunction

    function void clear_line();
        line_phase = cltok_pkg::PH_IDLE;
        name_len   = '0;
        arg_len    = '0;
        args_begun = '0;
        first_len  = '0;
        second_len = '0;
        escaped    = 1'b0;
    endfunction

    function void push_event(logic [1:0] kind, logic [3:0] err, logic [1:0] slot,
                             logic [5:0] pos, logic [7:0] ch, logic [5:0] l0,
                             logic [6:0] l1, logic [6:0] l2);
        t_token_event ev;
        ev.kind     = kind;
        ev.err      = err;
        ev.slot     = slot;
        ev.pos      = pos;
        ev.ch       = ch;
        ev.argc     = args_begun;
        ev.name_len = l0;
        ev.len1     = l1;
        ev.len2     = l2;
        expected_events.push_back(ev);
    endfunction

    function void syntax_error(logic [3:0] err);
        line_phase = cltok_pkg::PH_ERROR;
        push_event(cltok_pkg::EV_ERROR, err, 2'd0, 6'd0, 8'd0, 6'd0, 7'd0, 7'd0);
    endfunction

    function void store_arg_char(logic [7:0] b);
        if (arg_len >= cltok_pkg::ARG_MAX) begin
            syntax_error(cltok_pkg::ERR_ARG_LONG);
        end else begin
            push_event(cltok_pkg::EV_CHAR, cltok_pkg::ERR_NONE, args_begun, arg_len[5:0], b,
                       6'd0, 7'd0, 7'd0);
            arg_len = arg_len + 7'd1;
        end
    endfunction

    function void close_arg();
        if (args_begun == 2'd1)
            first_len = arg_len;
        else if (args_begun == 2'd2)
            second_len = arg_len;
    endfunction

    function void line_done();
        push_event(cltok_pkg::EV_READY, cltok_pkg::ERR_NONE, 2'd0, 6'd0, 8'd0, name_len,
                   first_len, second_len);
        clear_line();
    endfunction

    // Advances the line state by one accepted byte and queues the word it should cause.
    function void note_byte(logic [7:0] b);
        case (line_phase)
            cltok_pkg::PH_IDLE: begin
                if (is_letter(b)) begin
                    name_len   = 6'd1;
                    line_phase = cltok_pkg::PH_NAME;
                    push_event(cltok_pkg::EV_CHAR, cltok_pkg::ERR_NONE, 2'd0, 6'd0, b,
                               6'd0, 7'd0, 7'd0);
                end else if (!is_eol(b)) begin
                    syntax_error(cltok_pkg::ERR_BAD_START);
                end
            end
            cltok_pkg::PH_NAME: begin
                if (is_eol(b)) begin
                    line_done();
                end else if (is_blank(b)) begin
                    line_phase = cltok_pkg::PH_EXPECT;
                end else if (!is_name_byte(b)) begin
                    syntax_error(cltok_pkg::ERR_NAME_CHAR);
                end else if (name_len >= cltok_pkg::NAME_MAX) begin
                    syntax_error(cltok_pkg::ERR_NAME_LONG);
                end else begin
                    push_event(cltok_pkg::EV_CHAR, cltok_pkg::ERR_NONE, 2'd0, name_len, b,
                               6'd0, 7'd0, 7'd0);
                    name_len = name_len + 6'd1;
                end
            end
            cltok_pkg::PH_EXPECT: begin
                arg_len = '0;
                if (is_eol(b)) begin
                    // A trailing blank ends the line at once, with no discarding.
                    push_event(cltok_pkg::EV_ERROR, cltok_pkg::ERR_MISSING, 2'd0, 6'd0, 8'd0,
                               6'd0, 7'd0, 7'd0);
                    clear_line();
                end else if (is_blank(b)) begin
                    syntax_error(cltok_pkg::ERR_EXTRA_SP);
                end else if (args_begun >= cltok_pkg::ARGS_MAX) begin
                    syntax_error(cltok_pkg::ERR_TOO_MANY);
                end else begin
                    args_begun = args_begun + 2'd1;
                    if (b == cltok_pkg::CH_QUOTE) begin
                        escaped    = 1'b0;
                        line_phase = cltok_pkg::PH_QUOTED;
                    end else begin
                        line_phase = cltok_pkg::PH_BARE;
                        store_arg_char(b);
                    end
                end
            end
            cltok_pkg::PH_BARE: begin
                if (is_eol(b)) begin
                    close_arg();
                    line_done();
                end else if (is_blank(b)) begin
                    close_arg();
                    line_phase = cltok_pkg::PH_EXPECT;
                end else begin
                    store_arg_char(b);
                end
            end
            cltok_pkg::PH_QUOTED: begin
                if (b == cltok_pkg::CH_QUOTE || b == cltok_pkg::CH_BACKSLASH) begin
                    if (escaped) begin
                        escaped = 1'b0;
                        store_arg_char(b);
                    end else if (b == cltok_pkg::CH_QUOTE) begin
                        line_phase = cltok_pkg::PH_CLOSED;
                    end else begin
                        escaped = 1'b1;
                    end
                end else begin
                    escaped = 1'b0;
                    store_arg_char(b);
                end
            end
            cltok_pkg::PH_CLOSED: begin
                if (is_eol(b)) begin
                    close_arg();
                    line_done();
                end else if (is_blank(b)) begin
                    close_arg();
                    line_phase = cltok_pkg::PH_EXPECT;
                end else begin
                    syntax_error(cltok_pkg::ERR_JUNK_QUOTE);
                end
            end
            default: begin
                if (is_eol(b))
                    clear_line();
            end
        endcase
    endfunction

    function void compare_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_event(t_token_event got);
        t_token_event want;
        if (expected_events.size() == 0) begin
            $error("unexpected word: event_kind %0d, error_kind %0d", got.kind, got.err);
            errors++;
            return;
        end
        want = expected_events.pop_front();
        compare_field("event_kind", want.kind, got.kind);
        compare_field("error_kind", want.err, got.err);
        compare_field("token_slot", want.slot, got.slot);
        compare_field("char_position", want.pos, got.pos);
        compare_field("char_byte", want.ch, got.ch);
        compare_field("argument_count", want.argc, got.argc);
        compare_field("name_length", want.name_len, got.name_len);
        compare_field("first_arg_length", want.len1, got.len1);
        compare_field("second_arg_length", want.len2, got.len2);
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        LINE_GOOD, LINE_BAD_START, LINE_NAME_LONG, LINE_NAME_CHAR, LINE_MISSING,
        LINE_EXTRA_SP, LINE_TOO_MANY, LINE_ARG_LONG, LINE_JUNK, LINE_NOISE, LINE_EMPTY
    } t_line_shape;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // error_kind up to second_arg_length, as in the RTL
    logic [1:0]  m_axis_tuser;           // [1:0] event_kind

    t_token_event   observed;
    line_scoreboard board = new();
    logic [7:0]     line_bytes[$];
    int             sent_bytes    = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    // Empty line, quoted escapes with CR inside quotes, bare quote and backslash,
    // a high byte at the start, a trailing blank, and two blanks in a row.
    logic [7:0] opening_bytes [25] = '{
        cltok_pkg::CH_LF,
        8'h5A, cltok_pkg::CH_SPACE, cltok_pkg::CH_QUOTE, cltok_pkg::CH_BACKSLASH,
        cltok_pkg::CH_QUOTE, cltok_pkg::CH_BACKSLASH, cltok_pkg::CH_BACKSLASH,
        cltok_pkg::CH_BACKSLASH, cltok_pkg::CH_CR, cltok_pkg::CH_QUOTE, cltok_pkg::CH_SPACE,
        cltok_pkg::CH_BACKSLASH, cltok_pkg::CH_QUOTE, cltok_pkg::CH_LF,
        8'hFF, 8'h00, cltok_pkg::CH_CR,
        8'h61, cltok_pkg::CH_TAB, cltok_pkg::CH_LF,
        8'h7A, cltok_pkg::CH_SPACE, cltok_pkg::CH_SPACE, cltok_pkg::CH_LF
    };

    command_line_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign observed = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[5:4], m_axis_tdata[11:6],
                       m_axis_tdata[19:12], m_axis_tdata[21:20], m_axis_tdata[27:22],
                       m_axis_tdata[34:28], m_axis_tdata[41:35]};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_event(observed);
    end

    function automatic logic [7:0] letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(3))
            0, 1:    return letter();
            2:       return 8'h30 + 8'($urandom_range(9));
            default: return $urandom_range(1) ? cltok_pkg::CH_DASH : cltok_pkg::CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] bare_char();
        logic [7:0] b;
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? cltok_pkg::CH_QUOTE : cltok_pkg::CH_BACKSLASH;
        do b = 8'($urandom); while (is_blank(b) || is_eol(b));
        return b;
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(1) ? cltok_pkg::CH_SPACE : cltok_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(1) ? cltok_pkg::CH_CR : cltok_pkg::CH_LF;
    endfunction

    // Appends one argument that stores the given number of characters; a bare argument stores at least one.
    function automatic void add_arg(int chars, bit quoted);
        logic [7:0] b;
        if (!quoted) begin
            do b = bare_char(); while (b == cltok_pkg::CH_QUOTE);
            line_bytes.push_back(b);
            repeat (chars - 1) line_bytes.push_back(bare_char());
        end else begin
            line_bytes.push_back(cltok_pkg::CH_QUOTE);
            repeat (chars) begin
                case ($urandom_range(5))
                    0: begin
                        line_bytes.push_back(cltok_pkg::CH_BACKSLASH);
                        line_bytes.push_back($urandom_range(1) ? cltok_pkg::CH_QUOTE
                                                               : cltok_pkg::CH_BACKSLASH);
                    end
                    1: begin
                        line_bytes.push_back(cltok_pkg::CH_BACKSLASH);
                        line_bytes.push_back(8'($urandom));
                    end
                    default: begin
                        do b = 8'($urandom);
                        while (b == cltok_pkg::CH_QUOTE || b == cltok_pkg::CH_BACKSLASH);
                        line_bytes.push_back(b);
                    end
                endcase
            end
            line_bytes.push_back(cltok_pkg::CH_QUOTE);
        end
    endfunction

    function automatic void build_line();
        t_line_shape shape;
        int          name_chars;
        int          arg_total;
        int          arg_chars;
        int          k;
        logic [7:0]  b;
        line_bytes.delete();
        shape = LINE_GOOD;
        if ($urandom_range(1) == 1)
            shape = t_line_shape'($urandom_range(LINE_BAD_START, LINE_EMPTY));
        // Overlong arguments cost many words, so they are drawn less often.
        if (shape == LINE_ARG_LONG && $urandom_range(2) != 0)
            shape = LINE_JUNK;
        case (shape)
            LINE_EMPTY: ;
            LINE_NOISE: repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom));
            LINE_BAD_START: begin
                do b = 8'($urandom); while (is_letter(b) || is_eol(b));
                line_bytes.push_back(b);
            end
            default: begin
                if (shape == LINE_NAME_LONG)
                    name_chars = cltok_pkg::NAME_MAX + 1;
                else if ($urandom_range(15) == 0)
                    name_chars = cltok_pkg::NAME_MAX;
                else
                    name_chars = $urandom_range(1, 6);
                line_bytes.push_back(letter());
                repeat (name_chars - 1) line_bytes.push_back(name_char());
                if (shape == LINE_NAME_CHAR) begin
                    do b = 8'($urandom); while (is_name_byte(b) || is_blank(b) || is_eol(b));
                    line_bytes.push_back(b);
                end
                if (shape == LINE_TOO_MANY)
                    arg_total = cltok_pkg::ARGS_MAX + 1;
                else if (shape == LINE_ARG_LONG || shape == LINE_JUNK)
                    arg_total = $urandom_range(1, cltok_pkg::ARGS_MAX);
                else
                    arg_total = $urandom_range(0, cltok_pkg::ARGS_MAX);
                for (k = 0; k < arg_total; k++) begin
                    arg_chars = ($urandom_range(19) == 0) ? cltok_pkg::ARG_MAX
                                                          : $urandom_range(0, 5);
                    if (shape == LINE_ARG_LONG && k == arg_total - 1)
                        arg_chars = cltok_pkg::ARG_MAX + 1;
                    line_bytes.push_back(blank());
                    add_arg(arg_chars, (shape == LINE_JUNK && k == arg_total - 1) ?
                                       1'b1 : 1'($urandom_range(1)));
                end
                if (shape == LINE_JUNK)
                    line_bytes.push_back(bare_char());
                if (shape == LINE_MISSING || shape == LINE_EXTRA_SP)
                    line_bytes.push_back(blank());
                if (shape == LINE_EXTRA_SP)
                    line_bytes.push_back(blank());
            end
        endcase
        // After a syntax error the rest of the line is thrown away by the block.
        if (shape != LINE_GOOD && shape != LINE_MISSING && shape != LINE_EMPTY)
            repeat ($urandom_range(0, 3)) line_bytes.push_back(bare_char());
        line_bytes.push_back(line_end());
    endfunction

    // Offers one byte after a random gap and returns at the edge where it is taken.
    task automatic send_byte(logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_byte(b);
        sent_bytes++;
    endtask

    initial begin
        int round;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 80;
        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        for (round = 0; round < 3; round++) begin
            case (round)
                0:       begin send_idle_pct = 14; recv_idle_pct = 80; end
                1:       begin send_idle_pct = 80; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            while (sent_bytes < 25 + 150 * (round + 1)) begin
                build_line();
                foreach (line_bytes[i]) send_byte(line_bytes[i]);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.expected_events.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
